/* rtl/ypvt_pkg.sv */
// shared types, register indexes and constants of the yaw/pitch view transform
package ypvt_pkg;

    localparam int COORD_W            = 32;
    localparam int DIFF_W             = COORD_W + 1;
    localparam int CFG_DATA_W         = 32;
    localparam int REG_IDX_W          = 3;
    localparam int ANGLE_REG_W        = 12;
    localparam int DEF_ANGLE_BITS     = 12;
    localparam int DEF_TRIG_FRAC_BITS = 16;

    typedef logic [REG_IDX_W-1:0] t_reg_idx;

    localparam t_reg_idx REG_YAW_ANGLE   = 3'd0;
    localparam t_reg_idx REG_PITCH_ANGLE = 3'd1;
    localparam t_reg_idx REG_BOX_X_START = 3'd2;
    localparam t_reg_idx REG_BOX_X_END   = 3'd3;
    localparam t_reg_idx REG_BOX_Y_START = 3'd4;
    localparam t_reg_idx REG_BOX_Y_END   = 3'd5;
    localparam t_reg_idx REG_EYE_DEPTH   = 3'd6;

    // basis entries, row major: right, down, forward
    localparam int BASIS_N    = 9;
    localparam int BI_RIGHT_X = 0;
    localparam int BI_RIGHT_Z = 2;
    localparam int BI_DOWN_X  = 3;
    localparam int BI_DOWN_Y  = 4;
    localparam int BI_DOWN_Z  = 5;
    localparam int BI_FWD_X   = 6;
    localparam int BI_FWD_Y   = 7;
    localparam int BI_FWD_Z   = 8;

    // sine polynomial, q30
    localparam int POLY_W = 33;
    localparam int MUL_B_W = 32;
    localparam int MUL_W = POLY_W + MUL_B_W;
    localparam logic [30:0] Q30_ONE = 31'h4000_0000;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_USE  = 5'b00100,
        ST_PMUL = 5'b01000,
        ST_PUSE = 5'b10000
    } t_seq_state;

    function automatic logic signed [POLY_W-1:0] poly_coef(input logic [2:0] k);
        logic signed [POLY_W-1:0] c;
        case (k)
            3'd0: c = 33'sd1686629713;
            3'd1: c = -33'sd693598668;
            3'd2: c = 33'sd85569306;
            3'd3: c = -33'sd5026996;
            3'd4: c = 33'sd172272;
            3'd5: c = -33'sd3864;
            3'd6: c = 33'sd61;
            default: c = 33'sd0;
        endcase
        return c;
    endfunction

endpackage

/* rtl/ypvt_basis.sv */
// sine/cosine sequencer that builds the camera basis from yaw and pitch
module ypvt_basis #(
    parameter int ANGLE_BITS     = ypvt_pkg::DEF_ANGLE_BITS,
    parameter int TRIG_FRAC_BITS = ypvt_pkg::DEF_TRIG_FRAC_BITS,
    parameter int BASIS_W        = TRIG_FRAC_BITS + 2
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [ypvt_pkg::ANGLE_REG_W-1:0]    i_yaw,
    input  logic [ypvt_pkg::ANGLE_REG_W-1:0]    i_pitch,
    output logic                                o_busy,
    output logic signed [BASIS_W-1:0]           o_basis [ypvt_pkg::BASIS_N]
);
    import ypvt_pkg::*;

    localparam int RND_SH = 30 - TRIG_FRAC_BITS;
    localparam logic [31:0] RND_HALF = 32'd1 << (RND_SH - 1);
    localparam logic signed [MUL_W-1:0] PRD_HALF =
        {{(MUL_W-1){1'b0}}, 1'b1} << (TRIG_FRAC_BITS - 1);
    localparam logic signed [BASIS_W-1:0] TRIG_ONE =
        {{(BASIS_W-1){1'b0}}, 1'b1} << TRIG_FRAC_BITS;

    localparam logic [2:0] STEP_SQ  = 3'd0;
    localparam logic [2:0] STEP_FIN = 3'd7;
    localparam logic [1:0] SIN_YAW   = 2'd0;
    localparam logic [1:0] COS_YAW   = 2'd1;
    localparam logic [1:0] SIN_PITCH = 2'd2;
    localparam logic [1:0] COS_PITCH = 2'd3;
    localparam logic [1:0] PRD_SY_SP = 2'd0;
    localparam logic [1:0] PRD_CY_SP = 2'd1;
    localparam logic [1:0] PRD_SY_CP = 2'd2;
    localparam logic [1:0] PRD_CY_CP = 2'd3;

    t_seq_state                 r_state;
    logic [1:0]                 r_sel;
    logic [1:0]                 r_psel;
    logic [2:0]                 r_step;
    logic [30:0]                r_x2;
    logic signed [POLY_W-1:0]   r_acc;
    logic signed [MUL_W-1:0]    r_prod;
    logic signed [BASIS_W-1:0]  r_sin [4];
    logic signed [BASIS_W-1:0]  r_basis [BASIS_N];

    logic [ANGLE_BITS-1:0]      ang;
    logic [31:0]                phase;
    logic [1:0]                 quad;
    logic [30:0]                xoff;
    logic signed [POLY_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [MUL_W-1:0]    mul_p;
    logic signed [MUL_W-1:0]    prod_sh;
    logic signed [POLY_W-1:0]   horner;
    logic signed [33:0]         s_raw;
    logic [30:0]                s_cl;
    logic [31:0]                s_rnd;
    logic signed [BASIS_W-1:0]  sine_mag;
    logic signed [BASIS_W-1:0]  sine_v;
    logic signed [MUL_W-1:0]    t_rnd;
    logic signed [BASIS_W-1:0]  t_v;

    // phase of the current sine; cosine is a quarter turn ahead
    always_comb begin
        ang   = ANGLE_BITS'(r_sel[1] ? i_pitch : i_yaw);
        phase = {ang, {(32-ANGLE_BITS){1'b0}}};
        quad  = phase[31:30] + {1'b0, r_sel[0]};
        xoff  = quad[0] ? (Q30_ONE - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};
    end

    always_comb begin
        case (r_state)
            ST_PMUL: begin
                mul_a = POLY_W'(r_sin[{1'b0, r_psel[0]}]);
                mul_b = MUL_B_W'(r_sin[{1'b1, r_psel[1]}]);
            end
            default: begin
                if (r_step == STEP_SQ) begin
                    mul_a = $signed({2'b00, xoff});
                    mul_b = $signed({1'b0, xoff});
                end else if (r_step == STEP_FIN) begin
                    mul_a = r_acc;
                    mul_b = $signed({1'b0, xoff});
                end else begin
                    mul_a = r_acc;
                    mul_b = $signed({1'b0, r_x2});
                end
            end
        endcase
        mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);
    end

    always_comb begin
        prod_sh = r_prod >>> 30;
        horner  = poly_coef(3'd6 - r_step) + $signed(prod_sh[POLY_W-1:0]);
        s_raw   = $signed(prod_sh[33:0]);
        if (s_raw[33]) begin
            s_cl = '0;
        end else if (s_raw > $signed({3'b000, Q30_ONE})) begin
            s_cl = Q30_ONE;
        end else begin
            s_cl = s_raw[30:0];
        end
        s_rnd    = ({1'b0, s_cl} + RND_HALF) >> RND_SH;
        sine_mag = $signed(BASIS_W'(s_rnd[TRIG_FRAC_BITS:0]));
        sine_v   = quad[1] ? -sine_mag : sine_mag;
        t_rnd    = (r_prod + PRD_HALF) >>> TRIG_FRAC_BITS;
        t_v      = BASIS_W'(t_rnd);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        if (r_state == ST_USE) begin
            if (r_step == STEP_SQ) begin
                r_x2  <= prod_sh[30:0];
                r_acc <= poly_coef(3'd6);
            end else if (r_step == STEP_FIN) begin
                r_sin[r_sel] <= sine_v;
            end else begin
                r_acc <= horner;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sel   <= '0;
            r_step  <= '0;
            r_psel  <= '0;
            for (int k = 0; k < BASIS_N; k++) begin
                if (k == BI_RIGHT_X || k == BI_DOWN_Y || k == BI_FWD_Z) begin
                    r_basis[k] <= TRIG_ONE;
                end else begin
                    r_basis[k] <= '0;
                end
            end
        end else if (i_start) begin
            r_state <= ST_MUL;
            r_sel   <= '0;
            r_step  <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    r_state <= ST_IDLE;
                end
                ST_MUL: begin
                    r_state <= ST_USE;
                end
                ST_USE: begin
                    if (r_step == STEP_FIN) begin
                        case (r_sel)
                            SIN_YAW:   r_basis[BI_RIGHT_Z] <= -sine_v;
                            COS_YAW:   r_basis[BI_RIGHT_X] <= sine_v;
                            SIN_PITCH: r_basis[BI_FWD_Y]   <= -sine_v;
                            default:   r_basis[BI_DOWN_Y]  <= sine_v;
                        endcase
                        if (r_sel == COS_PITCH) begin
                            r_state <= ST_PMUL;
                            r_psel  <= '0;
                        end else begin
                            r_sel   <= r_sel + 2'd1;
                            r_step  <= STEP_SQ;
                            r_state <= ST_MUL;
                        end
                    end else begin
                        r_step  <= r_step + 3'd1;
                        r_state <= ST_MUL;
                    end
                end
                ST_PMUL: begin
                    r_state <= ST_PUSE;
                end
                ST_PUSE: begin
                    case (r_psel)
                        PRD_SY_SP: r_basis[BI_DOWN_X] <= t_v;
                        PRD_CY_SP: r_basis[BI_DOWN_Z] <= t_v;
                        PRD_SY_CP: r_basis[BI_FWD_X]  <= t_v;
                        default:   r_basis[BI_FWD_Z]  <= t_v;
                    endcase
                    if (r_psel == PRD_CY_CP) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_psel  <= r_psel + 2'd1;
                        r_state <= ST_PMUL;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_busy  = (r_state != ST_IDLE);
    assign o_basis = r_basis;

endmodule

/* rtl/yaw_pitch_view_transform.sv */
// top level: vertex rotation about the camera eye with yaw/pitch basis
// One vertex item is taken per cycle unless a basis rebuild or a stalled output holds the
// input; its result passes the input register and then the output register, and a stalled
// output holds one result while the input register still takes the next item. After reset
// the identity basis and a zero eye are in place at once. Every configuration write to a
// listed register starts a rebuild of the basis in a sequencer with one shared 33x32
// multiplier (four Horner sine evaluations of eight products each, then four basis
// products): the input is stalled while the rebuild runs, and a further write restarts it.
module yaw_pitch_view_transform #(
    parameter int ANGLE_BITS     = ypvt_pkg::DEF_ANGLE_BITS,
    parameter int TRIG_FRAC_BITS = ypvt_pkg::DEF_TRIG_FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  ypvt_pkg::t_reg_idx                  i_cfg_index,
    input  logic [ypvt_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [ypvt_pkg::COORD_W-1:0] i_vertex_x,
    input  logic signed [ypvt_pkg::COORD_W-1:0] i_vertex_y,
    input  logic signed [ypvt_pkg::COORD_W-1:0] i_vertex_z,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [ypvt_pkg::COORD_W-1:0] o_out_x,
    output logic signed [ypvt_pkg::COORD_W-1:0] o_out_y,
    output logic signed [ypvt_pkg::COORD_W-1:0] o_out_z
);
    import ypvt_pkg::*;

    localparam int BASIS_W = TRIG_FRAC_BITS + 2;
    localparam int PROD_W  = BASIS_W + DIFF_W;
    localparam int DOT_W   = PROD_W + 2;
    localparam int SUM_W   = DOT_W + 1;
    localparam logic signed [DOT_W-1:0] DOT_HALF =
        {{(DOT_W-1){1'b0}}, 1'b1} << (TRIG_FRAC_BITS - 1);

    logic [ANGLE_REG_W-1:0]     r_yaw;
    logic [ANGLE_REG_W-1:0]     r_pitch;
    logic signed [COORD_W-1:0]  r_box_x_start;
    logic signed [COORD_W-1:0]  r_box_x_end;
    logic signed [COORD_W-1:0]  r_box_y_start;
    logic signed [COORD_W-1:0]  r_box_y_end;
    logic signed [COORD_W-1:0]  r_eye_depth;
    logic signed [COORD_W-1:0]  r_eye [3];
    logic signed [COORD_W-1:0]  r_vtx [3];
    logic signed [COORD_W-1:0]  r_out [3];
    logic                       r_in_valid;
    logic                       r_out_valid;
    logic                       n_in_valid;
    logic                       n_out_valid;

    logic                       cfg_hit;
    logic                       basis_busy;
    logic signed [BASIS_W-1:0]  basis [BASIS_N];
    logic                       out_adv;
    logic                       in_fire;
    logic signed [DIFF_W-1:0]   eye_x_sum;
    logic signed [DIFF_W-1:0]   eye_y_sum;
    logic signed [DIFF_W-1:0]   diff [3];
    logic signed [PROD_W-1:0]   prod [3][3];
    logic signed [DOT_W-1:0]    dot [3];
    logic signed [DOT_W-1:0]    rnd [3];
    logic signed [SUM_W-1:0]    sum [3];
    logic signed [COORD_W-1:0]  sat [3];

    // configuration registers
    always_comb begin
        case (i_cfg_index)
            REG_YAW_ANGLE, REG_PITCH_ANGLE, REG_BOX_X_START, REG_BOX_X_END,
            REG_BOX_Y_START, REG_BOX_Y_END, REG_EYE_DEPTH: cfg_hit = 1'b1;
            default: cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yaw         <= '0;
            r_pitch       <= '0;
            r_box_x_start <= '0;
            r_box_x_end   <= '0;
            r_box_y_start <= '0;
            r_box_y_end   <= '0;
            r_eye_depth   <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_YAW_ANGLE:   r_yaw         <= i_cfg_data[ANGLE_REG_W-1:0];
                REG_PITCH_ANGLE: r_pitch       <= i_cfg_data[ANGLE_REG_W-1:0];
                REG_BOX_X_START: r_box_x_start <= $signed(i_cfg_data[COORD_W-1:0]);
                REG_BOX_X_END:   r_box_x_end   <= $signed(i_cfg_data[COORD_W-1:0]);
                REG_BOX_Y_START: r_box_y_start <= $signed(i_cfg_data[COORD_W-1:0]);
                REG_BOX_Y_END:   r_box_y_end   <= $signed(i_cfg_data[COORD_W-1:0]);
                REG_EYE_DEPTH:   r_eye_depth   <= $signed(i_cfg_data[COORD_W-1:0]);
                default: ;
            endcase
        end
    end

    // eye: box midpoint in x and y, floored
    always_comb begin
        eye_x_sum = DIFF_W'(r_box_x_start) + DIFF_W'(r_box_x_end);
        eye_y_sum = DIFF_W'(r_box_y_start) + DIFF_W'(r_box_y_end);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eye[0] <= '0;
            r_eye[1] <= '0;
            r_eye[2] <= '0;
        end else begin
            r_eye[0] <= eye_x_sum[DIFF_W-1:1];
            r_eye[1] <= eye_y_sum[DIFF_W-1:1];
            r_eye[2] <= r_eye_depth;
        end
    end

    ypvt_basis #(
        .ANGLE_BITS     (ANGLE_BITS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS),
        .BASIS_W        (BASIS_W)
    ) u_basis (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cfg_wr_en && cfg_hit),
        .i_yaw   (r_yaw),
        .i_pitch (r_pitch),
        .o_busy  (basis_busy),
        .o_basis (basis)
    );

    // item handshake
    always_comb begin
        out_adv     = !r_out_valid || !i_out_stall;
        o_in_stall  = basis_busy || (r_in_valid && !out_adv);
        in_fire     = i_in_valid && !o_in_stall;
        n_in_valid  = in_fire || (r_in_valid && !out_adv);
        n_out_valid = out_adv ? r_in_valid : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_vtx[0] <= i_vertex_x;
            r_vtx[1] <= i_vertex_y;
            r_vtx[2] <= i_vertex_z;
        end
        if (out_adv && r_in_valid) begin
            r_out <= sat;
        end
    end

    // rotate about the eye, round, re-center, saturate
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            diff[j] = DIFF_W'(r_vtx[j]) - DIFF_W'(r_eye[j]);
        end
        for (int r = 0; r < 3; r++) begin
            for (int j = 0; j < 3; j++) begin
                prod[r][j] = PROD_W'(basis[3*r+j]) * PROD_W'(diff[j]);
            end
            dot[r] = DOT_W'(prod[r][0]) + DOT_W'(prod[r][1]) + DOT_W'(prod[r][2]);
            rnd[r] = (dot[r] + DOT_HALF) >>> TRIG_FRAC_BITS;
            sum[r] = SUM_W'(rnd[r]) + SUM_W'(r_eye[r]);
            if ((&sum[r][SUM_W-1:COORD_W-1]) || !(|sum[r][SUM_W-1:COORD_W-1])) begin
                sat[r] = sum[r][COORD_W-1:0];
            end else if (sum[r][SUM_W-1]) begin
                sat[r] = {1'b1, {(COORD_W-1){1'b0}}};
            end else begin
                sat[r] = {1'b0, {(COORD_W-1){1'b1}}};
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_x     = r_out[0];
    assign o_out_y     = r_out[1];
    assign o_out_z     = r_out[2];

endmodule

/* rtl/ypvt_checker.sv */
// port-level assertions for the view transform, bound to the top level
module ypvt_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_cfg_wr_en,
    input ypvt_pkg::t_reg_idx                  i_cfg_index,
    input logic                                i_in_valid,
    input logic                                o_in_stall,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic [ypvt_pkg::COORD_W-1:0]        o_out_x,
    input logic [ypvt_pkg::COORD_W-1:0]        o_out_y,
    input logic [ypvt_pkg::COORD_W-1:0]        o_out_z
);
    import ypvt_pkg::*;

    // a listed register write holds off items while the basis is rebuilt
    a_cfg_stalls: assert property (@(posedge i_clk)
        i_rst_n && i_cfg_wr_en && (i_cfg_index <= REG_EYE_DEPTH) |=> o_in_stall)
        else $error("input not stalled after configuration write");

    // an accepted item is followed by a valid result at the output, after the input and output registers
    a_item_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |-> ##2 o_out_valid)
        else $error("accepted item produced no result");

    // reset leaves no result and an open input
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("state after reset not clear");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_out_x) && $stable(o_out_y) && $stable(o_out_z))
        else $error("stalled result changed");

endmodule

bind yaw_pitch_view_transform ypvt_checker u_checker (.*);

/* test/tb_top.sv */
// self-checking testbench for the yaw/pitch view transform: random vertices under many camera setups
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ypvt_pkg::*;

    localparam int ANGLE_BITS     = DEF_ANGLE_BITS;
    localparam int TRIG_FRAC_BITS = DEF_TRIG_FRAC_BITS;
    localparam int HOLD_CYCLES    = 250;
    localparam int MAX_REPORTS    = 40;
    localparam longint Q30_UNIT   = longint'(1) << 30;
    localparam t_reg_idx REG_UNUSED = 3'd7;
    localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_coord3;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_wr_en = 1'b0;
    t_reg_idx                  i_cfg_index = REG_YAW_ANGLE;
    logic [CFG_DATA_W-1:0]     i_cfg_data = '0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic signed [COORD_W-1:0] i_vertex_x = '0;
    logic signed [COORD_W-1:0] i_vertex_y = '0;
    logic signed [COORD_W-1:0] i_vertex_z = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic signed [COORD_W-1:0] o_out_x;
    logic signed [COORD_W-1:0] o_out_y;
    logic signed [COORD_W-1:0] o_out_z;

    yaw_pitch_view_transform dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_vertex_x  (i_vertex_x),
        .i_vertex_y  (i_vertex_y),
        .i_vertex_z  (i_vertex_z),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_out_z     (o_out_z)
    );

    // camera setup as the block should hold it
    logic [ANGLE_REG_W-1:0]    cam_yaw = '0;
    logic [ANGLE_REG_W-1:0]    cam_pitch = '0;
    logic signed [COORD_W-1:0] box_xs = '0;
    logic signed [COORD_W-1:0] box_xe = '0;
    logic signed [COORD_W-1:0] box_ys = '0;
    logic signed [COORD_W-1:0] box_ye = '0;
    logic signed [COORD_W-1:0] eye_z = '0;
    longint                    basis [BASIS_N];
    longint                    eye_pt [3];

    t_coord3 pending_vertices [$];
    t_coord3 expected_views [$];
    t_coord3 next_vertex;
    t_coord3 want;
    int      items_offered = 0;
    int      results_seen = 0;
    int      fail_count = 0;
    int      send_gap = 0;
    int      stall_left = 0;
    int      hold_left = 0;
    bit      hold_req = 1'b0;
    bit      no_idle = 1'b0;
    bit      in_taken = 1'b0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic longint sine_coef(int k);
        case (k)
            0: return 1686629713;
            1: return -693598668;
            2: return 85569306;
            3: return -5026996;
            4: return 172272;
            5: return -3864;
            default: return 61;
        endcase
    endfunction

    function automatic longint phase_sine(logic [31:0] phase);
        longint x;
        longint x2;
        longint acc;
        longint s;
        int     k;
        x = phase[29:0];
        if (phase[30]) begin
            x = Q30_UNIT - x;
        end
        x2 = (x * x) >>> 30;
        acc = sine_coef(6);
        for (k = 5; k >= 0; k--) begin
            acc = sine_coef(k) + ((acc * x2) >>> 30);
        end
        s = (acc * x) >>> 30;
        if (s < 0) begin
            s = 0;
        end
        if (s > Q30_UNIT) begin
            s = Q30_UNIT;
        end
        s = (s + (longint'(1) << (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
        return phase[31] ? -s : s;
    endfunction

    function automatic longint trig_mul(longint a, longint b);
        return (a * b + (longint'(1) << (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS;
    endfunction

    function automatic void rederive_view();
        logic [31:0] py;
        logic [31:0] pp;
        longint      sy;
        longint      cy;
        longint      sp;
        longint      cp;
        py = cam_yaw[ANGLE_BITS-1:0];
        py = py << (32 - ANGLE_BITS);
        pp = cam_pitch[ANGLE_BITS-1:0];
        pp = pp << (32 - ANGLE_BITS);
        sy = phase_sine(py);
        cy = phase_sine(py + 32'h4000_0000);
        sp = phase_sine(pp);
        cp = phase_sine(pp + 32'h4000_0000);
        basis[BI_RIGHT_X]     = cy;
        basis[BI_RIGHT_X + 1] = 0;
        basis[BI_RIGHT_Z]     = -sy;
        basis[BI_DOWN_X]      = trig_mul(sy, sp);
        basis[BI_DOWN_Y]      = cp;
        basis[BI_DOWN_Z]      = trig_mul(cy, sp);
        basis[BI_FWD_X]       = trig_mul(sy, cp);
        basis[BI_FWD_Y]       = -sp;
        basis[BI_FWD_Z]       = trig_mul(cy, cp);
        eye_pt[0] = (longint'(box_xs) + longint'(box_xe)) >>> 1;
        eye_pt[1] = (longint'(box_ys) + longint'(box_ye)) >>> 1;
        eye_pt[2] = longint'(eye_z);
    endfunction

    function automatic logic signed [COORD_W-1:0] to_coord(longint v);
        if (v > longint'(C_MAX)) begin
            return C_MAX;
        end
        if (v < longint'(C_MIN)) begin
            return C_MIN;
        end
        return v[COORD_W-1:0];
    endfunction

    function automatic t_coord3 view_of(t_coord3 v);
        longint  d [3];
        longint  res [3];
        longint  dot;
        t_coord3 r;
        int      i;
        d[0] = longint'(v.x) - eye_pt[0];
        d[1] = longint'(v.y) - eye_pt[1];
        d[2] = longint'(v.z) - eye_pt[2];
        for (i = 0; i < 3; i++) begin
            dot = basis[3*i] * d[0] + basis[3*i+1] * d[1] + basis[3*i+2] * d[2];
            res[i] = eye_pt[i] + ((dot + (longint'(1) << (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS);
        end
        r.x = to_coord(res[0]);
        r.y = to_coord(res[1]);
        r.z = to_coord(res[2]);
        return r;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) begin
            return 0;
        end
        if (r < 85) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 50);
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_coord();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) begin
            return C_MAX;
        end
        if (r == 1) begin
            return C_MIN;
        end
        if (r < 7) begin
            return $urandom;
        end
        return $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_angle();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'd1024;
            2: return 32'd2048;
            3: return 32'd3072;
            4: return 32'd4095;
            default: return $urandom;
        endcase
    endfunction

    task automatic write_reg(t_reg_idx idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            REG_YAW_ANGLE:   cam_yaw = val[ANGLE_REG_W-1:0];
            REG_PITCH_ANGLE: cam_pitch = val[ANGLE_REG_W-1:0];
            REG_BOX_X_START: box_xs = val;
            REG_BOX_X_END:   box_xe = val;
            REG_BOX_Y_START: box_ys = val;
            REG_BOX_Y_END:   box_ye = val;
            REG_EYE_DEPTH:   eye_z = val;
            default: ;
        endcase
        if (idx <= REG_EYE_DEPTH) begin
            rederive_view();
        end
        @(negedge i_clk);
    endtask

    task automatic end_writes();
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic offer(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                         logic signed [COORD_W-1:0] z);
        t_coord3 c;
        c.x = x;
        c.y = y;
        c.z = z;
        pending_vertices.push_back(c);
        items_offered++;
    endtask

    task automatic push_corners();
        offer(0, 0, 0);
        offer(C_MAX, C_MAX, C_MAX);
        offer(C_MIN, C_MIN, C_MIN);
        offer(C_MAX, C_MIN, C_MAX);
        offer(C_MIN, C_MAX, C_MIN);
        offer(-1, -1, -1);
        offer(32'sh0001_0000, -32'sh0001_0000, 32'sh0001_0000);
        offer($urandom, $urandom, $urandom);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (results_seen != items_offered) begin
            @(negedge i_clk);
        end
    endtask

    task automatic check_field(string name, logic signed [COORD_W-1:0] exp_v,
                               logic signed [COORD_W-1:0] act_v);
        if (act_v !== exp_v) begin
            if (fail_count < MAX_REPORTS) begin
                $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            end
            fail_count++;
        end
    endtask

    // vertex driver
    always @(negedge i_clk) begin
        if (!i_in_valid || in_taken) begin
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_vertices.size() > 0) begin
                next_vertex = pending_vertices.pop_front();
                i_vertex_x <= next_vertex.x;
                i_vertex_y <= next_vertex.y;
                i_vertex_z <= next_vertex.z;
                i_in_valid <= 1'b1;
                send_gap = idle_len();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result receiver stalls
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            stall_left = idle_len();
            i_out_stall <= 1'b0;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        in_taken = i_rst_n && i_in_valid && !o_in_stall;
        if (in_taken) begin
            expected_views.push_back(view_of('{i_vertex_x, i_vertex_y, i_vertex_z}));
        end
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (expected_views.size() == 0) begin
                if (fail_count < MAX_REPORTS) begin
                    $error("result item with nothing expected: %0d %0d %0d",
                           o_out_x, o_out_y, o_out_z);
                end
                fail_count++;
            end else begin
                want = expected_views.pop_front();
                check_field("out_x", want.x, o_out_x);
                check_field("out_y", want.y, o_out_y);
                check_field("out_z", want.z, o_out_z);
                results_seen++;
            end
        end
    end

    initial begin
        int p;
        int n;
        int k;
        rederive_view();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;
        @(posedge i_clk);

        // identity basis, eye at origin
        push_corners();
        wait_drained();

        // quarter yaw, three-quarter pitch, box sums overflowing 32 bits
        write_reg(REG_YAW_ANGLE, 32'd1024);
        write_reg(REG_PITCH_ANGLE, 32'd3072);
        write_reg(REG_BOX_X_START, C_MAX);
        write_reg(REG_BOX_X_END, C_MAX);
        write_reg(REG_BOX_Y_START, C_MIN);
        write_reg(REG_BOX_Y_END, C_MIN);
        write_reg(REG_EYE_DEPTH, C_MAX);
        end_writes();
        push_corners();
        wait_drained();

        // angle upper bits ignored, box reversed, unused index
        write_reg(REG_YAW_ANGLE, 32'hFFFF_FFFF);
        write_reg(REG_PITCH_ANGLE, 32'hABCD_E800);
        write_reg(REG_BOX_X_START, 32'sh03E8_0000);
        write_reg(REG_BOX_X_END, -32'sh03E8_0001);
        write_reg(REG_BOX_Y_START, 32'sh0000_0003);
        write_reg(REG_BOX_Y_END, -32'sh0010_0000);
        write_reg(REG_EYE_DEPTH, C_MIN);
        write_reg(REG_UNUSED, 32'h0000_0400);
        end_writes();
        push_corners();
        wait_drained();

        for (p = 0; p < 12; p++) begin
            write_reg(REG_YAW_ANGLE, rand_angle());
            write_reg(REG_PITCH_ANGLE, rand_angle());
            if ($urandom_range(0, 1) == 1 || p == 0) begin
                write_reg(REG_BOX_X_START, rand_coord());
                write_reg(REG_BOX_X_END, rand_coord());
                write_reg(REG_BOX_Y_START, rand_coord());
                write_reg(REG_BOX_Y_END, rand_coord());
            end
            if ($urandom_range(0, 2) == 0) begin
                write_reg(REG_EYE_DEPTH, rand_coord());
            end
            if (p == 7) begin
                write_reg(REG_UNUSED, $urandom);
            end
            end_writes();
            no_idle = (p == 3 || p == 9);
            n = (p == 5) ? 120 : 60;
            for (k = 0; k < n; k++) begin
                offer(rand_coord(), rand_coord(), rand_coord());
            end
            if (p == 5) begin
                hold_req = 1'b1;
            end
            wait_drained();
        end

        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && expected_views.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
